### rtl/core/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: field widths, sector codes and the
// fixed-point constants used by the pipeline.
// No dependencies.
package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int SEC_W   = 3;
    localparam int K_W     = 6;
    localparam int PROD_W  = 14;   // v*(100-s) and v*s, at most 10000
    localparam int NUM_W   = 20;   // middle numerator, at most 600000

    // Arithmetic constants
    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 9'd360;
    localparam logic [HUE_W-1:0] SECTOR_SPAN   = 9'd60;
    localparam logic [PCT_W-1:0] PERCENT_FULL  = 7'd100;

    // floor(x/100) = (x*RECIP_100) >> 20, exact for x below 43690
    localparam logic [PROD_W-1:0] RECIP_100   = 14'd10486;
    localparam int                RECIP_100_SH = 20;
    // floor(x/6000) = (x*RECIP_6000) >> 32, exact for x below 6.1M
    localparam logic [NUM_W-1:0]  RECIP_6000   = 20'd715828;
    localparam int                RECIP_6000_SH = 32;

    // Hue sectors, 60 degrees each
    typedef logic [SEC_W-1:0] sector_t;
    localparam sector_t SECTOR_0 = 3'd0;   // red top, green middle, blue bottom
    localparam sector_t SECTOR_1 = 3'd1;   // green top, red middle, blue bottom
    localparam sector_t SECTOR_2 = 3'd2;   // green top, blue middle, red bottom
    localparam sector_t SECTOR_3 = 3'd3;   // blue top, green middle, red bottom
    localparam sector_t SECTOR_4 = 3'd4;   // blue top, red middle, green bottom
    localparam sector_t SECTOR_5 = 3'd5;   // red top, blue middle, green bottom

    // Start angle of each sector
    function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
        logic [HUE_W-1:0] base;
        case (sec)
            SECTOR_0: base = 9'd0;
            SECTOR_1: base = 9'd60;
            SECTOR_2: base = 9'd120;
            SECTOR_3: base = 9'd180;
            SECTOR_4: base = 9'd240;
            default:  base = 9'd300;
        endcase
        return base;
    endfunction

endpackage

### rtl/core/hsv_to_rgb_convert_unit.sv
// HSV to RGB converter, five-stage pipeline with per-stage valid bits.
// Depends on hsv2rgb_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries hue 0..359 degrees, saturation
//   and brightness 0..100 percent. Output channel (out_valid/out_ready)
//   carries red, green, blue 0..100 percent, one result beat per input beat,
//   in order. Hue above 359 is reduced by 360; saturation and brightness
//   above 100 are treated as 100.
//   Path: the edge that accepts a beat loads stage 1; the beat then passes
//   through stages 2..4 and then the output stage into the output register.
//   Throughput: one beat per cycle while out_ready is high; each stage holds
//   at most one beat, and the three multiply stages (v*(100-s), v*s; then the
//   numerator and the reciprocal multiply for /100; then the reciprocal
//   multiply for /6000) are each registered.
//   Stalls: each stage loads when it is empty or its successor loads, so
//   bubbles squeeze out and up to five beats are held while out_ready is
//   low; in_ready drops only when all five stages are full.
//   Reset: rst_n clears all valid bits; the pipeline starts empty.
module hsv_to_rgb_convert_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [8:0] hue,
    input  logic [6:0] saturation,
    input  logic [6:0] brightness,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] red,
    output logic [6:0] green,
    output logic [6:0] blue
);

    localparam int HW = hsv2rgb_pkg::HUE_W;
    localparam int PW = hsv2rgb_pkg::PCT_W;
    localparam int KW = hsv2rgb_pkg::K_W;
    localparam int XW = hsv2rgb_pkg::PROD_W;
    localparam int NW = hsv2rgb_pkg::NUM_W;

    // Stage load enables, back to front
    logic ld1, ld2, ld3, ld4, ld_out;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    assign ld_out   = !out_valid_reg || out_ready;
    assign ld4      = !v4_reg || ld_out;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)    v1_reg        <= in_valid;
            if (ld2)    v2_reg        <= v1_reg;
            if (ld3)    v3_reg        <= v2_reg;
            if (ld4)    v4_reg        <= v3_reg;
            if (ld_out) out_valid_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: range fixup, sector and sector offset
    // ---------------------------------------------------------------
    logic [HW-1:0]            hue_fix;
    hsv2rgb_pkg::sector_t     sec_next;
    logic [HW-1:0]            offs_full;
    logic [KW-1:0]            offs;
    logic [KW-1:0]            k_next;
    logic [PW-1:0]            sat_next, val_next;

    always_comb
    begin
        hue_fix = (hue >= hsv2rgb_pkg::HUE_FULL_TURN) ?
                  hue - hsv2rgb_pkg::HUE_FULL_TURN : hue;
        sat_next = (saturation > hsv2rgb_pkg::PERCENT_FULL) ?
                   hsv2rgb_pkg::PERCENT_FULL : saturation;
        val_next = (brightness > hsv2rgb_pkg::PERCENT_FULL) ?
                   hsv2rgb_pkg::PERCENT_FULL : brightness;
        // thermometer compare against sector boundaries
        sec_next = hsv2rgb_pkg::SECTOR_0;
        if (hue_fix >= 9'd60)  sec_next = hsv2rgb_pkg::SECTOR_1;
        if (hue_fix >= 9'd120) sec_next = hsv2rgb_pkg::SECTOR_2;
        if (hue_fix >= 9'd180) sec_next = hsv2rgb_pkg::SECTOR_3;
        if (hue_fix >= 9'd240) sec_next = hsv2rgb_pkg::SECTOR_4;
        if (hue_fix >= 9'd300) sec_next = hsv2rgb_pkg::SECTOR_5;
        offs_full = hue_fix - hsv2rgb_pkg::sector_base(sec_next);
        offs      = offs_full[KW-1:0];
        // k rises through even sectors, falls through odd ones
        k_next = sec_next[0] ? (hsv2rgb_pkg::SECTOR_SPAN[KW-1:0] - offs) : offs;
    end

    hsv2rgb_pkg::sector_t s1_sec_reg;
    logic [KW-1:0]        s1_k_reg;
    logic [PW-1:0]        s1_sat_reg, s1_val_reg;

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            s1_sec_reg <= sec_next;
            s1_k_reg   <= k_next;
            s1_sat_reg <= sat_next;
            s1_val_reg <= val_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: products v*(100-s) and v*s
    // ---------------------------------------------------------------
    logic [PW-1:0] inv_sat;
    logic [XW-1:0] a_next, b_next;

    assign inv_sat = hsv2rgb_pkg::PERCENT_FULL - s1_sat_reg;
    assign a_next  = XW'(s1_val_reg) * XW'(inv_sat);
    assign b_next  = XW'(s1_val_reg) * XW'(s1_sat_reg);

    hsv2rgb_pkg::sector_t s2_sec_reg;
    logic [KW-1:0]        s2_k_reg;
    logic [PW-1:0]        s2_val_reg;
    logic [XW-1:0]        s2_a_reg, s2_b_reg;

    always_ff @(posedge clk)
    begin
        if (ld2 && v1_reg)
        begin
            s2_sec_reg <= s1_sec_reg;
            s2_k_reg   <= s1_k_reg;
            s2_val_reg <= s1_val_reg;
            s2_a_reg   <= a_next;
            s2_b_reg   <= b_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: middle numerator a*60 + b*k, bottom = a/100
    // ---------------------------------------------------------------
    logic [NW-1:0]   a60, bk, num_next;
    logic [2*XW-1:0] bot_prod;
    logic [PW-1:0]   bot_next;

    assign a60      = (NW'(s2_a_reg) << 6) - (NW'(s2_a_reg) << 2);
    assign bk       = NW'(s2_b_reg) * NW'(s2_k_reg);
    assign num_next = a60 + bk;
    assign bot_prod = (2*XW)'(s2_a_reg) * (2*XW)'(hsv2rgb_pkg::RECIP_100);
    assign bot_next = bot_prod[hsv2rgb_pkg::RECIP_100_SH +: PW];

    hsv2rgb_pkg::sector_t s3_sec_reg;
    logic [PW-1:0]        s3_val_reg, s3_bot_reg;
    logic [NW-1:0]        s3_num_reg;

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            s3_sec_reg <= s2_sec_reg;
            s3_val_reg <= s2_val_reg;
            s3_bot_reg <= bot_next;
            s3_num_reg <= num_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: middle = num/6000 by reciprocal multiply
    // ---------------------------------------------------------------
    logic [2*NW-1:0] mid_prod;
    logic [PW-1:0]   mid_next;

    assign mid_prod = (2*NW)'(s3_num_reg) * (2*NW)'(hsv2rgb_pkg::RECIP_6000);
    assign mid_next = mid_prod[hsv2rgb_pkg::RECIP_6000_SH +: PW];

    hsv2rgb_pkg::sector_t s4_sec_reg;
    logic [PW-1:0]        s4_val_reg, s4_bot_reg, s4_mid_reg;

    always_ff @(posedge clk)
    begin
        if (ld4 && v3_reg)
        begin
            s4_sec_reg <= s3_sec_reg;
            s4_val_reg <= s3_val_reg;
            s4_bot_reg <= s3_bot_reg;
            s4_mid_reg <= mid_next;
        end
    end

    // ---------------------------------------------------------------
    // Output stage: route top/middle/bottom by sector
    // ---------------------------------------------------------------
    logic [PW-1:0] r_next, g_next, b_next_ch;

    always_comb
    begin
        case (s4_sec_reg)
            hsv2rgb_pkg::SECTOR_0:
            begin
                r_next = s4_val_reg; g_next = s4_mid_reg; b_next_ch = s4_bot_reg;
            end
            hsv2rgb_pkg::SECTOR_1:
            begin
                r_next = s4_mid_reg; g_next = s4_val_reg; b_next_ch = s4_bot_reg;
            end
            hsv2rgb_pkg::SECTOR_2:
            begin
                r_next = s4_bot_reg; g_next = s4_val_reg; b_next_ch = s4_mid_reg;
            end
            hsv2rgb_pkg::SECTOR_3:
            begin
                r_next = s4_bot_reg; g_next = s4_mid_reg; b_next_ch = s4_val_reg;
            end
            hsv2rgb_pkg::SECTOR_4:
            begin
                r_next = s4_mid_reg; g_next = s4_bot_reg; b_next_ch = s4_val_reg;
            end
            default:
            begin
                r_next = s4_val_reg; g_next = s4_bot_reg; b_next_ch = s4_mid_reg;
            end
        endcase
    end

    logic [PW-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk)
    begin
        if (ld_out && v4_reg)
        begin
            red_reg   <= r_next;
            green_reg <= g_next;
            blue_reg  <= b_next_ch;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

`ifndef SYNTHESIS
    // Input stalls only when every stage holds a beat and the sink stalls
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg && !out_ready))
        else $error("in_ready low while pipeline not full");

    // Sector code stays within the six sectors
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (s4_sec_reg <= hsv2rgb_pkg::SECTOR_5))
        else $error("sector code out of range");

    // Channel ordering: bottom <= middle <= top
    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (s4_bot_reg <= s4_mid_reg && s4_mid_reg <= s4_val_reg))
        else $error("bottom/middle/top out of order");

    // Every delivered channel lies in 0..100
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (red <= 7'd100 && green <= 7'd100 && blue <= 7'd100))
        else $error("output channel above 100 percent");
`endif

endmodule
